### design/assert_macros.svh
// Assertion macros shared by the balance tilt controller modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/btc_pkg.sv
// Types, constants and the arctangent table of the balance tilt controller
`timescale 1ns / 1ps

package btc_pkg;

    typedef struct packed {
        logic signed [15:0] gyro;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [9:0]  speed;
    } t_item;

    localparam logic [2:0] REG_K_ANGLE    = 3'd0;
    localparam logic [2:0] REG_K_RATE     = 3'd1;
    localparam logic [2:0] REG_K_SPEED    = 3'd2;
    localparam logic [2:0] REG_K_POSITION = 3'd3;
    localparam logic [2:0] REG_ACCEL_Y_OFS = 3'd4;
    localparam logic [2:0] REG_ACCEL_Z_OFS = 3'd5;
    localparam logic [2:0] REG_GYRO_OFS   = 3'd6;
    localparam logic [2:0] REG_ENABLE     = 3'd7;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [25:0] DEG90_Q16 = 26'sd5898240;
    localparam logic signed [17:0] W_OLD = 18'sd65274;
    localparam logic signed [9:0]  W_NEW = 10'sd262;
    localparam logic [31:0] TILT_HI = 32'd655360;
    localparam logic [31:0] TILT_LO = 32'd26215;
    localparam logic [47:0] DRIVE_MAX = 48'd255;
    localparam logic signed [23:0] TILT_OUT_MAX = 24'sd46080;
    localparam logic [16:0] RECIP_131 = 17'd32017;
    localparam int SHIFT_131 = 22;
    localparam logic [16:0] RECIP_10 = 17'd104857;
    localparam int SHIFT_10 = 20;

    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

### design/btc_front.sv
// Front end: takes sensor beats, removes calibration offsets, pushes to the queue
`timescale 1ns / 1ps

module btc_front (
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [63:0]        i_data,
    input  logic signed [15:0] i_gyro_ofs,
    input  logic signed [15:0] i_accel_y_ofs,
    input  logic signed [15:0] i_accel_z_ofs,
    input  logic               i_q_full,
    output logic               o_push,
    output btc_pkg::t_item     o_item
);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item.gyro    = $signed(i_data[15:0]) - i_gyro_ofs;
        o_item.accel_y = $signed(i_data[31:16]) - i_accel_y_ofs;
        o_item.accel_z = $signed(i_data[47:32]) - i_accel_z_ofs;
        o_item.speed   = $signed(i_data[57:48]);
    end

endmodule

### design/btc_queue.sv
// Two-entry queue between the front and back ends
`timescale 1ns / 1ps
`include "assert_macros.svh"

module btc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  btc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output btc_pkg::t_item o_item
);

    btc_pkg::t_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count != 2'd3)
    `ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != 2'd0)
    `ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, i_push, r_count != 2'd2)

endmodule

### design/btc_back.sv
// Back end: CORDIC tilt, complementary blend, rate filter and drive sum
`timescale 1ns / 1ps
`include "assert_macros.svh"

module btc_back #(
    parameter int CORDIC_STEPS   = 16,
    parameter int POSITION_LIMIT = 110
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  btc_pkg::t_item     i_item,
    output logic               o_pop,
    input  logic signed [31:0] i_k_angle,
    input  logic signed [31:0] i_k_rate,
    input  logic signed [31:0] i_k_speed,
    input  logic signed [31:0] i_k_position,
    input  logic               i_enable,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_data
);

    localparam int ITERS = (CORDIC_STEPS < btc_pkg::ATAN_ENTRIES) ?
                           CORDIC_STEPS : btc_pkg::ATAN_ENTRIES;
    localparam logic [4:0] LAST_ITER = 5'(ITERS - 1);
    localparam logic signed [7:0] POS_MAX = 8'(POSITION_LIMIT);
    localparam logic signed [7:0] POS_MIN = -8'(POSITION_LIMIT);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CORD   = 4'd1;
    localparam logic [3:0] S_BLEND1 = 4'd2;
    localparam logic [3:0] S_BLEND2 = 4'd3;
    localparam logic [3:0] S_DIV1   = 4'd4;
    localparam logic [3:0] S_DIV2   = 4'd5;
    localparam logic [3:0] S_RF1    = 4'd6;
    localparam logic [3:0] S_RF2    = 4'd7;
    localparam logic [3:0] S_MUL0   = 4'd8;
    localparam logic [3:0] S_MUL1   = 4'd9;
    localparam logic [3:0] S_MUL2   = 4'd10;
    localparam logic [3:0] S_MUL3   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0]          r_state;
    logic [3:0]          n_state;
    logic signed [15:0]  r_g;
    logic signed [9:0]   r_speed;
    logic signed [33:0]  r_f0;
    logic signed [18:0]  r_x;
    logic signed [18:0]  r_y;
    logic signed [25:0]  r_z;
    logic [4:0]          r_iter;
    logic                r_zero;
    logic signed [63:0]  r_prod;
    logic [35:0]         r_dq;
    logic signed [31:0]  r_fused;
    logic                r_upflag;
    logic signed [15:0]  r_rf;
    logic signed [7:0]   r_pos;
    logic signed [8:0]   r_gx;
    logic signed [19:0]  r_n;
    logic signed [63:0]  r_sum;
    logic                r_act;
    logic                r_out_valid;
    logic signed [8:0]   r_drive;
    logic                r_brake;
    logic                r_upright;
    logic signed [16:0]  r_tilt;

    logic signed [16:0]  xi;
    logic signed [16:0]  yi;
    logic signed [18:0]  dx;
    logic signed [18:0]  dy;
    logic signed [25:0]  atan_v;
    logic signed [25:0]  acc;
    logic signed [63:0]  blend;
    logic signed [47:0]  fsh;
    logic signed [31:0]  fsat;
    logic [31:0]         fmag;
    logic                up_next;
    logic [15:0]         gmag;
    logic [8:0]          q131;
    logic [15:0]         r131;
    logic [8:0]          q131c;
    logic [19:0]         nmag;
    logic [15:0]         q10;
    logic [19:0]         r10;
    logic [15:0]         q10c;
    logic signed [10:0]  pos_sum;
    logic signed [7:0]   pos_new;
    logic [63:0]         smag;
    logic [47:0]         pmag;
    logic signed [9:0]   pwm;
    logic signed [23:0]  tsh;
    logic signed [16:0]  tclamp;
    logic                out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = {4'd0, r_tilt, r_upright, r_brake, r_drive};

    always_comb begin
        xi     = -17'(i_item.accel_z);
        yi     = 17'(i_item.accel_y);
        dx     = r_y >>> r_iter;
        dy     = r_x >>> r_iter;
        atan_v = $signed({4'd0, btc_pkg::atan_q16(r_iter)});
        acc    = r_zero ? 26'sd0 : -r_z;
        blend  = r_prod + 64'(acc) * 64'(btc_pkg::W_NEW) + 64'sd32768;
        fsh    = blend[63:16];
        if (fsh > 48'sh0000_7FFF_FFFF) begin
            fsat = 32'h7FFF_FFFF;
        end else if (fsh < -48'sh0000_8000_0000) begin
            fsat = 32'h8000_0000;
        end else begin
            fsat = fsh[31:0];
        end
        fmag = fsat[31] ? 32'(-33'(fsat)) : fsat;
        up_next = r_upflag;
        if (fmag > btc_pkg::TILT_HI) begin
            up_next = 1'b0;
        end
        if (fmag < btc_pkg::TILT_LO) begin
            up_next = 1'b1;
        end
        gmag  = r_g[15] ? 16'(-17'(r_g)) : 16'(r_g);
        q131  = r_dq[btc_pkg::SHIFT_131 +: 9];
        r131  = gmag - 16'(q131) * 16'd131;
        q131c = (r131 >= 16'd131) ? q131 + 9'd1 : q131;
        nmag  = r_n[19] ? 20'(-21'(r_n)) : 20'(r_n);
        q10   = r_dq[btc_pkg::SHIFT_10 +: 16];
        r10   = nmag - 20'(q10) * 20'd10;
        q10c  = (r10 >= 20'd10) ? q10 + 16'd1 : q10;
        pos_sum = 11'(r_pos) + 11'(r_speed);
        if (pos_sum > 11'(POS_MAX)) begin
            pos_new = POS_MAX;
        end else if (pos_sum < 11'(POS_MIN)) begin
            pos_new = POS_MIN;
        end else begin
            pos_new = pos_sum[7:0];
        end
        smag = r_sum[63] ? -r_sum : r_sum;
        pmag = smag[63:16];
        if (pmag > btc_pkg::DRIVE_MAX) begin
            pwm = 10'sd255;
        end else begin
            pwm = $signed({2'd0, pmag[7:0]});
        end
        if (r_sum[63]) begin
            pwm = -pwm;
        end
        tsh = r_fused[31:8];
        if (tsh > btc_pkg::TILT_OUT_MAX) begin
            tclamp = 17'(btc_pkg::TILT_OUT_MAX);
        end else if (tsh < -btc_pkg::TILT_OUT_MAX) begin
            tclamp = -17'(btc_pkg::TILT_OUT_MAX);
        end else begin
            tclamp = tsh[16:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_q_valid) n_state = S_CORD;
            S_CORD:   if (r_iter == LAST_ITER) n_state = S_BLEND1;
            S_BLEND1: n_state = S_BLEND2;
            S_BLEND2: n_state = (up_next && i_enable) ? S_DIV1 : S_DONE;
            S_DIV1:   n_state = S_DIV2;
            S_DIV2:   n_state = S_RF1;
            S_RF1:    n_state = S_RF2;
            S_RF2:    n_state = S_MUL0;
            S_MUL0:   n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_MUL3;
            S_MUL3:   n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            case (r_state)
                S_IDLE: begin
                    r_g     <= i_item.gyro;
                    r_speed <= i_item.speed;
                    r_f0    <= 34'(r_fused) + 34'(i_item.gyro) * 34'sd10;
                    r_zero  <= (xi == 17'sd0) && (yi == 17'sd0);
                    r_iter  <= 5'd0;
                    if (xi < 0) begin
                        if (yi >= 0) begin
                            r_x <= 19'(yi);
                            r_y <= -19'(xi);
                            r_z <= btc_pkg::DEG90_Q16;
                        end else begin
                            r_x <= -19'(yi);
                            r_y <= 19'(xi);
                            r_z <= -btc_pkg::DEG90_Q16;
                        end
                    end else begin
                        r_x <= 19'(xi);
                        r_y <= 19'(yi);
                        r_z <= 26'sd0;
                    end
                end
                S_CORD: begin
                    r_iter <= r_iter + 5'd1;
                    if (r_y > 0) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + atan_v;
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - atan_v;
                    end
                end
                S_BLEND1: r_prod <= 64'(r_f0) * 64'(btc_pkg::W_OLD);
                S_BLEND2: begin
                    r_fused <= fsat;
                    r_act   <= up_next && i_enable;
                    if (!(up_next && i_enable)) begin
                        r_pos <= 8'sd0;
                    end
                end
                S_DIV1: r_dq <= 36'(gmag) * 36'(btc_pkg::RECIP_131);
                S_DIV2: r_gx <= r_g[15] ? -$signed(q131c) : $signed(q131c);
                S_RF1: begin
                    r_n  <= 20'(r_gx) * 20'sd4 + 20'(r_rf) * 20'sd6;
                end
                S_RF2: begin
                    r_dq <= 36'(nmag) * 36'(btc_pkg::RECIP_10);
                end
                S_MUL0: begin
                    r_rf  <= r_n[19] ? -$signed(q10c) : $signed(q10c);
                    r_pos <= pos_new;
                    r_sum <= (64'(i_k_angle) * 64'(r_fused)) >>> 16;
                end
                S_MUL1: r_sum <= r_sum + 64'(i_k_rate) * 64'(r_rf);
                S_MUL2: r_sum <= r_sum + 64'(i_k_speed) * 64'(r_speed);
                S_MUL3: r_sum <= r_sum + 64'(i_k_position) * 64'(r_pos);
                default: ;
            endcase
        end
        if (r_state == S_DONE && out_free) begin
            r_drive   <= r_act ? -pwm[8:0] : 9'sd0;
            r_brake   <= r_act;
            r_upright <= r_upflag;
            r_tilt    <= tclamp;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fused     <= 32'sd0;
            r_upflag    <= 1'b0;
            r_rf        <= 16'sd0;
            r_pos       <= 8'sd0;
            r_out_valid <= 1'b0;
            r_act       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_BLEND2) begin
                r_upflag <= up_next;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `ASSERT_IMPLY(a_brake_upright, i_clk, i_rst_n, r_out_valid && r_brake, r_upright)
    `ASSERT_IMPLY(a_idle_drive, i_clk, i_rst_n, r_out_valid && !r_brake, r_drive == 9'sd0)
    `ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, r_state == S_DONE && out_free, r_out_valid)

endmodule

### design/balance_tilt_controller.sv
// Top level of the balance tilt controller
//
// One sensor beat per control tick enters on the s_axis channel: tdata holds
// gyro X, accel Y, accel Z (16 bits each) and the wheel encoder delta.
// Calibration offsets, gains and enable are written on the cfg port
// (write enable, register index, data); the user is to write them only
// while the block is idle, which the block itself does not enforce.
// One result beat leaves on the m_axis channel per input beat: drive,
// brake, upright flag and fused tilt angle in signed Q9.8 degrees.
// The back end works one item at a time through the iterative CORDIC,
// the blend and, when the drive is active, the rate filter and the
// shared sequence of drive products; it takes the next item only once
// the last result has gone into the output register. A two-entry queue
// sits between front and back. Reset clears the queue, the tilt state,
// the filters and the registers to their defaults. While the receiver
// stalls the result holds in the output register, the back end waits,
// and the queue fills before s_axis_tready drops.
`timescale 1ns / 1ps

module balance_tilt_controller #(
    parameter int CORDIC_STEPS   = 16,
    parameter int POSITION_LIMIT = 110
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // gyro_rate_raw[15:0], accel_y_raw[31:16], accel_z_raw[47:32],
    // encoder_delta[57:48], zero fill above
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // motor_drive[8:0], brake_on[9], upright[10], tilt_angle[27:11], zero above
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic signed [31:0] r_k_angle;
    logic signed [31:0] r_k_rate;
    logic signed [31:0] r_k_speed;
    logic signed [31:0] r_k_position;
    logic signed [15:0] r_accel_y_ofs;
    logic signed [15:0] r_accel_z_ofs;
    logic signed [15:0] r_gyro_ofs;
    logic               r_enable;

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    btc_pkg::t_item push_item;
    btc_pkg::t_item pop_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_angle     <= 32'sd26214400;
            r_k_rate      <= 32'sd524288;
            r_k_speed     <= 32'sd3276800;
            r_k_position  <= 32'sd39;
            r_accel_y_ofs <= 16'sd0;
            r_accel_z_ofs <= 16'sd0;
            r_gyro_ofs    <= 16'sd0;
            r_enable      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                btc_pkg::REG_K_ANGLE:     r_k_angle     <= i_cfg_data;
                btc_pkg::REG_K_RATE:      r_k_rate      <= i_cfg_data;
                btc_pkg::REG_K_SPEED:     r_k_speed     <= i_cfg_data;
                btc_pkg::REG_K_POSITION:  r_k_position  <= i_cfg_data;
                btc_pkg::REG_ACCEL_Y_OFS: r_accel_y_ofs <= i_cfg_data[15:0];
                btc_pkg::REG_ACCEL_Z_OFS: r_accel_z_ofs <= i_cfg_data[15:0];
                btc_pkg::REG_GYRO_OFS:    r_gyro_ofs    <= i_cfg_data[15:0];
                btc_pkg::REG_ENABLE:      r_enable      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    btc_front u_front (
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_gyro_ofs    (r_gyro_ofs),
        .i_accel_y_ofs (r_accel_y_ofs),
        .i_accel_z_ofs (r_accel_z_ofs),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_item        (push_item)
    );

    btc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    btc_back #(
        .CORDIC_STEPS   (CORDIC_STEPS),
        .POSITION_LIMIT (POSITION_LIMIT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_item       (pop_item),
        .o_pop        (q_pop),
        .i_k_angle    (r_k_angle),
        .i_k_rate     (r_k_rate),
        .i_k_speed    (r_k_speed),
        .i_k_position (r_k_position),
        .i_enable     (r_enable),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata)
    );

endmodule
